>>> sv/euler_ideal_gas_cell_flux_defines.svh
// Assertion macros for the Euler cell flux block.
// Needs clk and rst_n in the scope of each use.
`ifndef EULER_IDEAL_GAS_CELL_FLUX_DEFINES_SVH
`define EULER_IDEAL_GAS_CELL_FLUX_DEFINES_SVH

// same-cycle implication
`define EIGCF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EIGCF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/eigcf_pkg.sv
// Package for the Euler cell flux block: constants, sequencer states and
// saturating Q16.16 helpers. No dependencies.
`default_nettype none
package eigcf_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int EXT_BITS  = WORD_BITS + FRAC_BITS;

    localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic signed [WORD_BITS-1:0] Q_ONE    = 32'sd65536;

    localparam logic [17:0] GAMMA_RST = 18'd91750;
    localparam logic [26:0] GASC_RST  = 27'd18808832;
    localparam logic [30:0] DT_RST    = 31'd655;
    localparam logic [30:0] DX_RST    = 31'd65536;

    typedef enum logic [1:0] {
        REG_GAMMA = 2'd0,
        REG_GASC  = 2'd1,
        REG_DT    = 2'd2,
        REG_DX    = 2'd3
    } reg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_U_GO, ST_U_WT, ST_UU, ST_KE, ST_PR, ST_GP, ST_G_GO, ST_G_WT,
        ST_A_GO, ST_A_WT, ST_T0_GO, ST_T0_WT, ST_T_GO, ST_T_WT, ST_MA_GO, ST_MA_WT,
        ST_PD, ST_C_GO, ST_C_WT, ST_MF, ST_EF, ST_OUT
    } state_t;

    function automatic logic [WORD_BITS-1:0] mag32(input logic signed [WORD_BITS-1:0] a);
        logic [WORD_BITS-1:0] r;
        r = a[WORD_BITS-1] ? (~a + 1'b1) : a;
        return r;
    endfunction

    function automatic logic signed [WORD_BITS-1:0] from_sm(input logic neg,
                                                            input logic [EXT_BITS-1:0] m);
        logic big;
        logic [WORD_BITS-1:0] lo;
        big = (m[EXT_BITS-1:WORD_BITS-1] != '0);
        lo  = m[WORD_BITS-1:0];
        if (neg)
            return big ? WORD_MIN : (~lo + 1'b1);
        else
            return big ? WORD_MAX : lo;
    endfunction

    function automatic logic signed [WORD_BITS-1:0] sat_add(input logic signed [WORD_BITS-1:0] a,
                                                            input logic signed [WORD_BITS-1:0] b);
        logic signed [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1])
            return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
        return s[WORD_BITS-1:0];
    endfunction

    function automatic logic signed [WORD_BITS-1:0] sat_sub(input logic signed [WORD_BITS-1:0] a,
                                                            input logic signed [WORD_BITS-1:0] b);
        logic signed [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1])
            return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
        return s[WORD_BITS-1:0];
    endfunction

    function automatic logic signed [WORD_BITS-1:0] mul_q(input logic signed [WORD_BITS-1:0] a,
                                                          input logic signed [WORD_BITS-1:0] b);
        logic [2*WORD_BITS-1:0] p;
        p = mag32(a) * mag32(b);
        return from_sm(a[WORD_BITS-1] ^ b[WORD_BITS-1], p[2*WORD_BITS-1:FRAC_BITS]);
    endfunction

endpackage
`default_nettype wire

>>> sv/eigcf_div.sv
// Restoring divider, one quotient bit per cycle: (a * 2^16) / b, saturated.
// Depends on eigcf_pkg.
`default_nettype none
module eigcf_div (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    input  wire logic signed [eigcf_pkg::WORD_BITS-1:0] dividend,
    input  wire logic        [eigcf_pkg::WORD_BITS-1:0] divisor,
    output logic                                        done,
    output logic signed [eigcf_pkg::WORD_BITS-1:0]      quotient
);
    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;
    logic [5:0]                         cnt_reg, cnt_next;
    logic                               neg_reg;
    logic [eigcf_pkg::EXT_BITS-1:0]     dv_reg, q_reg;
    logic [eigcf_pkg::WORD_BITS-1:0]    rem_reg, dsr_reg;
    logic [eigcf_pkg::WORD_BITS:0]      rem_s;
    logic                               ge;

    assign rem_s = {rem_reg, dv_reg[eigcf_pkg::EXT_BITS-1]};
    assign ge    = (rem_s >= {1'b0, dsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'(eigcf_pkg::EXT_BITS);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[eigcf_pkg::WORD_BITS-1];
            dv_reg  <= {eigcf_pkg::mag32(dividend), {eigcf_pkg::FRAC_BITS{1'b0}}};
            dsr_reg <= divisor;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            dv_reg  <= {dv_reg[eigcf_pkg::EXT_BITS-2:0], 1'b0};
            rem_reg <= ge ? eigcf_pkg::WORD_BITS'(rem_s - {1'b0, dsr_reg})
                          : rem_s[eigcf_pkg::WORD_BITS-1:0];
            q_reg   <= {q_reg[eigcf_pkg::EXT_BITS-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = eigcf_pkg::from_sm(neg_reg, q_reg);
endmodule
`default_nettype wire

>>> sv/eigcf_sqrt.sv
// Digit-by-digit square root, one bit pair per cycle: floor(sqrt(x * 2^16)).
// Depends on eigcf_pkg.
`default_nettype none
module eigcf_sqrt (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic [eigcf_pkg::WORD_BITS-1:0]     radicand,
    output logic                                     done,
    output logic [24:0]                              root
);
    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;
    logic [4:0]                         cnt_reg, cnt_next;
    logic [eigcf_pkg::EXT_BITS-1:0]     v_reg;
    logic [27:0]                        r_reg;
    logic [24:0]                        y_reg;
    logic [27:0]                        r_s, trial;
    logic                               ge;

    assign r_s   = {r_reg[25:0], v_reg[eigcf_pkg::EXT_BITS-1 -: 2]};
    assign trial = {1'b0, y_reg, 2'b01};
    assign ge    = (r_s >= trial);

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'(eigcf_pkg::EXT_BITS / 2);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg <= {radicand, {eigcf_pkg::FRAC_BITS{1'b0}}};
            r_reg <= '0;
            y_reg <= '0;
        end
        else if (busy_reg)
        begin
            v_reg <= {v_reg[eigcf_pkg::EXT_BITS-3:0], 2'b00};
            r_reg <= ge ? (r_s - trial) : r_s;
            y_reg <= {y_reg[23:0], ge};
        end
    end

    assign done = done_reg;
    assign root = y_reg;
endmodule
`default_nettype wire

>>> sv/euler_ideal_gas_cell_flux.sv
// Sequence from accept to out_valid: six divider passes, a square root and the single
// multiply steps. A zero gas constant, sound speed or width skips its divider pass;
// zero density goes from ST_U_GO straight to ST_OUT, negative pressure from ST_PR.
// Requests: one at a time; in_stall stays high until the output register loads.
// Reset: async active low; config registers return to defaults, running max CFL to zero.
// Depends on eigcf_pkg, eigcf_div, eigcf_sqrt and the assertion macro header.
`default_nettype none
`include "euler_ideal_gas_cell_flux_defines.svh"
module euler_ideal_gas_cell_flux (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [30:0]        density,
    input  wire logic signed [31:0] momentum,
    input  wire logic signed [31:0] total_energy,
    input  wire logic               first_cell,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      mass_flux,
    output logic signed [31:0]      momentum_flux,
    output logic signed [31:0]      energy_flux,
    output logic signed [31:0]      pressure,
    output logic signed [31:0]      velocity,
    output logic signed [31:0]      temperature,
    output logic signed [31:0]      min_speed,
    output logic signed [31:0]      max_speed,
    output logic [30:0]             mach_number,
    output logic [30:0]             cfl_number,
    output logic [30:0]             max_cfl,
    output logic                    bad_state
);
    eigcf_pkg::state_t state_reg, state_next;

    logic [17:0] gamma_reg;
    logic [26:0] gasc_reg;
    logic [30:0] dt_reg, dx_reg;
    logic [30:0] max_cfl_reg, max_cfl_next;
    logic        out_valid_reg;

    logic [30:0]        rho_reg;
    logic signed [31:0] m_reg, e_reg, u_reg, acc_reg, p_reg, g_reg, a_reg;
    logic signed [31:0] t_reg, mach_reg, cfl_reg, mf_reg, ef_reg;
    logic               first_reg, bad_reg;

    logic signed [31:0] mflux_o, eflux_o, p_o, u_o, t_o, smin_o, smax_o;
    logic [30:0]        mach_o, cfl_o;

    logic               accept, out_fire, cfg_wr;
    logic signed [31:0] mul_a, mul_b, mul_p;
    logic signed [31:0] smin, smax, spd, abs_u;
    logic [31:0]        spd_m;
    logic               div_start, div_done, sqrt_start, sqrt_done;
    logic signed [31:0] div_a, div_q;
    logic [31:0]        div_b;
    logic [24:0]        sqrt_y;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign in_stall = (state_reg != eigcf_pkg::ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_fire = (state_reg == eigcf_pkg::ST_OUT) && !(out_valid_reg && out_stall);

    always_comb
    begin
        unique case (eigcf_pkg::reg_idx_t'(paddr[3:2]))
            eigcf_pkg::REG_GAMMA: prdata = {14'd0, gamma_reg};
            eigcf_pkg::REG_GASC:  prdata = {5'd0, gasc_reg};
            eigcf_pkg::REG_DT:    prdata = {1'b0, dt_reg};
            eigcf_pkg::REG_DX:    prdata = {1'b0, dx_reg};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg <= eigcf_pkg::GAMMA_RST;
            gasc_reg  <= eigcf_pkg::GASC_RST;
            dt_reg    <= eigcf_pkg::DT_RST;
            dx_reg    <= eigcf_pkg::DX_RST;
        end
        else if (cfg_wr)
        begin
            unique case (eigcf_pkg::reg_idx_t'(paddr[3:2]))
                eigcf_pkg::REG_GAMMA: gamma_reg <= pwdata[17:0];
                eigcf_pkg::REG_GASC:  gasc_reg  <= pwdata[26:0];
                eigcf_pkg::REG_DT:    dt_reg    <= pwdata[30:0];
                eigcf_pkg::REG_DX:    dx_reg    <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    // shared multiplier and wave speeds
    assign mul_p = eigcf_pkg::mul_q(mul_a, mul_b);
    assign smin  = eigcf_pkg::sat_sub(u_reg, a_reg);
    assign smax  = eigcf_pkg::sat_add(u_reg, a_reg);
    assign spd_m = (eigcf_pkg::mag32(smin) > eigcf_pkg::mag32(smax)) ?
                   eigcf_pkg::mag32(smin) : eigcf_pkg::mag32(smax);
    assign spd   = eigcf_pkg::from_sm(1'b0, {16'd0, spd_m});
    assign abs_u = eigcf_pkg::from_sm(1'b0, {16'd0, eigcf_pkg::mag32(u_reg)});

    eigcf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    eigcf_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (g_reg),
        .done     (sqrt_done),
        .root     (sqrt_y)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            eigcf_pkg::ST_IDLE:  if (accept) state_next = eigcf_pkg::ST_U_GO;
            eigcf_pkg::ST_U_GO:  state_next = bad_reg ? eigcf_pkg::ST_OUT : eigcf_pkg::ST_U_WT;
            eigcf_pkg::ST_U_WT:  if (div_done) state_next = eigcf_pkg::ST_UU;
            eigcf_pkg::ST_UU:    state_next = eigcf_pkg::ST_KE;
            eigcf_pkg::ST_KE:    state_next = eigcf_pkg::ST_PR;
            eigcf_pkg::ST_PR:    state_next = mul_p[31] ? eigcf_pkg::ST_OUT : eigcf_pkg::ST_GP;
            eigcf_pkg::ST_GP:    state_next = eigcf_pkg::ST_G_GO;
            eigcf_pkg::ST_G_GO:  state_next = eigcf_pkg::ST_G_WT;
            eigcf_pkg::ST_G_WT:  if (div_done) state_next = eigcf_pkg::ST_A_GO;
            eigcf_pkg::ST_A_GO:  state_next = eigcf_pkg::ST_A_WT;
            eigcf_pkg::ST_A_WT:  if (sqrt_done) state_next = eigcf_pkg::ST_T0_GO;
            eigcf_pkg::ST_T0_GO: state_next = eigcf_pkg::ST_T0_WT;
            eigcf_pkg::ST_T0_WT: if (div_done) state_next = eigcf_pkg::ST_T_GO;
            eigcf_pkg::ST_T_GO:  state_next = (gasc_reg == '0) ? eigcf_pkg::ST_MA_GO
                                                               : eigcf_pkg::ST_T_WT;
            eigcf_pkg::ST_T_WT:  if (div_done) state_next = eigcf_pkg::ST_MA_GO;
            eigcf_pkg::ST_MA_GO: state_next = (a_reg == '0) ? eigcf_pkg::ST_PD
                                                            : eigcf_pkg::ST_MA_WT;
            eigcf_pkg::ST_MA_WT: if (div_done) state_next = eigcf_pkg::ST_PD;
            eigcf_pkg::ST_PD:    state_next = eigcf_pkg::ST_C_GO;
            eigcf_pkg::ST_C_GO:  state_next = (dx_reg == '0) ? eigcf_pkg::ST_MF
                                                             : eigcf_pkg::ST_C_WT;
            eigcf_pkg::ST_C_WT:  if (div_done) state_next = eigcf_pkg::ST_MF;
            eigcf_pkg::ST_MF:    state_next = eigcf_pkg::ST_EF;
            eigcf_pkg::ST_EF:    state_next = eigcf_pkg::ST_OUT;
            eigcf_pkg::ST_OUT:   if (out_fire) state_next = eigcf_pkg::ST_IDLE;
            default:             state_next = eigcf_pkg::ST_IDLE;
        endcase
    end

    // unit controls and operand select
    always_comb
    begin
        div_start  = 1'b0;
        div_a      = '0;
        div_b      = '0;
        sqrt_start = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        unique case (state_reg)
            eigcf_pkg::ST_U_GO:
            begin
                div_start = !bad_reg;
                div_a     = m_reg;
                div_b     = {1'b0, rho_reg};
            end
            eigcf_pkg::ST_UU:
            begin
                mul_a = u_reg;
                mul_b = u_reg;
            end
            eigcf_pkg::ST_KE:
            begin
                mul_a = acc_reg;
                mul_b = {1'b0, rho_reg};
            end
            eigcf_pkg::ST_PR:
            begin
                mul_a = {14'd0, gamma_reg} - eigcf_pkg::Q_ONE;
                mul_b = eigcf_pkg::sat_sub(e_reg, acc_reg);
            end
            eigcf_pkg::ST_GP:
            begin
                mul_a = {14'd0, gamma_reg};
                mul_b = p_reg;
            end
            eigcf_pkg::ST_G_GO:
            begin
                div_start = 1'b1;
                div_a     = g_reg;
                div_b     = {1'b0, rho_reg};
            end
            eigcf_pkg::ST_A_GO: sqrt_start = 1'b1;
            eigcf_pkg::ST_T0_GO:
            begin
                div_start = 1'b1;
                div_a     = p_reg;
                div_b     = {1'b0, rho_reg};
            end
            eigcf_pkg::ST_T_GO:
            begin
                div_start = (gasc_reg != '0);
                div_a     = t_reg;
                div_b     = {5'd0, gasc_reg};
            end
            eigcf_pkg::ST_MA_GO:
            begin
                div_start = (a_reg != '0);
                div_a     = abs_u;
                div_b     = a_reg;
            end
            eigcf_pkg::ST_PD:
            begin
                mul_a = spd;
                mul_b = {1'b0, dt_reg};
            end
            eigcf_pkg::ST_C_GO:
            begin
                div_start = (dx_reg != '0);
                div_a     = g_reg;
                div_b     = {1'b0, dx_reg};
            end
            eigcf_pkg::ST_MF:
            begin
                mul_a = m_reg;
                mul_b = u_reg;
            end
            eigcf_pkg::ST_EF:
            begin
                mul_a = eigcf_pkg::sat_add(e_reg, p_reg);
                mul_b = u_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            eigcf_pkg::ST_IDLE:
                if (accept)
                begin
                    rho_reg   <= density;
                    m_reg     <= momentum;
                    e_reg     <= total_energy;
                    first_reg <= first_cell;
                    bad_reg   <= (density == '0);
                    u_reg     <= '0;
                    p_reg     <= '0;
                    a_reg     <= '0;
                    t_reg     <= '0;
                    mach_reg  <= '0;
                    cfl_reg   <= '0;
                    mf_reg    <= '0;
                    ef_reg    <= '0;
                end
            eigcf_pkg::ST_U_WT:  if (div_done) u_reg <= div_q;
            eigcf_pkg::ST_UU:    acc_reg <= mul_p;
            eigcf_pkg::ST_KE:    acc_reg <= mul_p >>> 1;
            eigcf_pkg::ST_PR:
            begin
                p_reg <= mul_p;
                if (mul_p[31])
                    bad_reg <= 1'b1;
            end
            eigcf_pkg::ST_GP:    g_reg <= mul_p;
            eigcf_pkg::ST_G_WT:  if (div_done) g_reg <= div_q;
            eigcf_pkg::ST_A_WT:  if (sqrt_done) a_reg <= {7'd0, sqrt_y};
            eigcf_pkg::ST_T0_WT: if (div_done) t_reg <= div_q;
            eigcf_pkg::ST_T_GO:
                if (gasc_reg == '0)
                    t_reg <= (p_reg == '0) ? '0 : eigcf_pkg::WORD_MAX;
            eigcf_pkg::ST_T_WT:  if (div_done) t_reg <= div_q;
            eigcf_pkg::ST_MA_GO:
                if (a_reg == '0)
                    mach_reg <= (u_reg == '0) ? '0 : eigcf_pkg::WORD_MAX;
            eigcf_pkg::ST_MA_WT: if (div_done) mach_reg <= div_q;
            eigcf_pkg::ST_PD:    g_reg <= mul_p;
            eigcf_pkg::ST_C_GO:
                if (dx_reg == '0)
                    cfl_reg <= (g_reg == '0) ? '0 : eigcf_pkg::WORD_MAX;
            eigcf_pkg::ST_C_WT:  if (div_done) cfl_reg <= div_q;
            eigcf_pkg::ST_MF:    mf_reg <= eigcf_pkg::sat_add(mul_p, p_reg);
            eigcf_pkg::ST_EF:    ef_reg <= mul_p;
            default: ;
        endcase
    end

    // running max; cfl_reg stays zero on a bad state
    always_comb
    begin
        if (first_reg || (cfl_reg[30:0] > max_cfl_reg))
            max_cfl_next = cfl_reg[30:0];
        else
            max_cfl_next = max_cfl_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= eigcf_pkg::ST_IDLE;
            max_cfl_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_fire)
            begin
                max_cfl_reg   <= max_cfl_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_fire)
        begin
            mflux_o   <= bad_reg ? '0 : mf_reg;
            eflux_o   <= bad_reg ? '0 : ef_reg;
            p_o       <= bad_reg ? '0 : p_reg;
            u_o       <= bad_reg ? '0 : u_reg;
            t_o       <= bad_reg ? '0 : t_reg;
            smin_o    <= bad_reg ? '0 : smin;
            smax_o    <= bad_reg ? '0 : smax;
            mach_o    <= bad_reg ? '0 : mach_reg[30:0];
            cfl_o     <= bad_reg ? '0 : cfl_reg[30:0];
            mass_flux <= m_reg;
            max_cfl   <= max_cfl_next;
            bad_state <= bad_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign momentum_flux = mflux_o;
    assign energy_flux   = eflux_o;
    assign pressure      = p_o;
    assign velocity      = u_o;
    assign temperature   = t_o;
    assign min_speed     = smin_o;
    assign max_speed     = smax_o;
    assign mach_number   = mach_o;
    assign cfl_number    = cfl_o;

    `EIGCF_ASSERT_NEXT(a_accept_busy, accept, state_reg != eigcf_pkg::ST_IDLE, "idle after accept")
    `EIGCF_ASSERT_NOW(a_max_ge_cfl, out_valid, max_cfl >= cfl_number, "max cfl below cfl")
    `EIGCF_ASSERT_NOW(a_bad_zero, out_valid && bad_state,
        (pressure == '0) && (cfl_number == '0), "bad state with nonzero results")
    `EIGCF_ASSERT_NOW(a_div_wait, div_done,
        (state_reg == eigcf_pkg::ST_U_WT) || (state_reg == eigcf_pkg::ST_G_WT) ||
        (state_reg == eigcf_pkg::ST_T0_WT) || (state_reg == eigcf_pkg::ST_T_WT) ||
        (state_reg == eigcf_pkg::ST_MA_WT) || (state_reg == eigcf_pkg::ST_C_WT),
        "divider done outside wait")
endmodule
`default_nettype wire

>>> sim/euler_ideal_gas_cell_flux_test.sv
// Self-checking testbench for euler_ideal_gas_cell_flux: directed cells, then random
// cells under several register settings, checked against a Q16.16 flux predictor.
// Depends on eigcf_pkg and the euler_ideal_gas_cell_flux RTL.
`timescale 1ns / 100ps
module euler_ideal_gas_cell_flux_test;

    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 400;
    localparam longint QMAX = 64'sd2147483647;
    localparam longint QMIN = -64'sd2147483648;

    typedef struct {
        longint mass, mom, energy, pres, vel, temp, smin, smax, mach, cfl, maxc;
        bit     bad;
    } flux_t;

    typedef struct {
        logic [30:0] rho;
        logic [31:0] m;
        logic [31:0] e;
        bit          first;
        bit          known;
    } cell_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [30:0] density = '0;
    logic signed [31:0] momentum = '0;
    logic signed [31:0] total_energy = '0;
    logic first_cell = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] mass_flux, momentum_flux, energy_flux, pressure, velocity;
    logic signed [31:0] temperature, min_speed, max_speed;
    logic [30:0] mach_number, cfl_number, max_cfl;
    logic bad_state;

    euler_ideal_gas_cell_flux u_dut (.*);

    // predictor state
    longint gamma_q = 91750, gasc_q = 18808832, dt_q = 655, dx_q = 65536;
    longint peak_cfl = 0;
    flux_t pending_flux[$];
    int errors = 0, cells_sent = 0, cells_checked = 0, settings_run = 0;
    int gap_pct = 0, stall_pct = 0;
    int quiet = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned q_mag(longint x);
        return (x < 0) ? longint'(-x) : x;
    endfunction

    function automatic longint q_sm(bit neg, longint unsigned m);
        if (neg)
            return (m >= 64'h8000_0000) ? QMIN : -longint'(m);
        return (m > 64'h7fff_ffff) ? QMAX : longint'(m);
    endfunction

    function automatic longint q_clip(longint s);
        return (s > QMAX) ? QMAX : (s < QMIN) ? QMIN : s;
    endfunction

    function automatic longint q_mul(longint a, longint b);
        longint unsigned p;
        p = (q_mag(a) * q_mag(b)) >> 16;
        return q_sm((a < 0) != (b < 0), p);
    endfunction

    function automatic longint q_div(longint a, longint b);
        longint unsigned x, y, q, r;
        bit neg;
        x = q_mag(a);
        y = q_mag(b);
        q = x / y;
        r = x % y;
        neg = (a < 0) != (b < 0);
        for (int i = 0; i < 16; i++) begin
            if (q > 64'h4000_0000)
                return q_sm(neg, '1);
            r = r << 1;
            q = q << 1;
            if (r >= y) begin
                r = r - y;
                q = q | 1;
            end
        end
        return q_sm(neg, q);
    endfunction

    function automatic longint q_sqrt(longint x);
        longint unsigned v, y, r, two, b;
        int s;
        v = x;
        y = 0;
        r = 0;
        for (int i = 23; i >= 0; i--) begin
            two = 0;
            for (int j = 1; j >= 0; j--) begin
                s = 2 * i + j - 16;
                b = (s >= 0) ? ((v >> s) & 1) : 0;
                two = (two << 1) | b;
            end
            r = (r << 2) | two;
            if (r >= ((y << 2) | 1)) begin
                r = r - ((y << 2) | 1);
                y = (y << 1) | 1;
            end else begin
                y = y << 1;
            end
        end
        return q_sm(1'b0, y);
    endfunction

    function automatic flux_t cell_flux(logic [30:0] rho_in, logic [31:0] m_in,
                                        logic [31:0] e_in, bit first);
        flux_t f;
        longint rho, m, e, u, p, ke, a, t, spd, prod, cfl;
        bit bad;
        rho = rho_in;
        m = longint'($signed(m_in));
        e = longint'($signed(e_in));
        u = 0;
        p = 0;
        cfl = 0;
        bad = (rho == 0);
        if (!bad) begin
            u = q_div(m, rho);
            ke = q_mul(q_mul(u, u), rho) >>> 1;
            p = q_mul(gamma_q - 65536, q_clip(e - ke));
            bad = (p < 0);
        end
        f = '{default: 0};
        f.mass = m;
        f.bad = bad;
        if (!bad) begin
            a = q_sqrt(q_div(q_mul(gamma_q, p), rho));
            t = q_div(p, rho);
            if (gasc_q == 0)
                t = (p == 0) ? 0 : QMAX;
            else
                t = q_div(t, gasc_q);
            f.smin = q_clip(u - a);
            f.smax = q_clip(u + a);
            if (a == 0)
                f.mach = (u == 0) ? 0 : QMAX;
            else
                f.mach = q_div(q_sm(1'b0, q_mag(u)), a);
            spd = q_sm(1'b0, (q_mag(f.smin) > q_mag(f.smax)) ? q_mag(f.smin) : q_mag(f.smax));
            prod = q_mul(spd, dt_q);
            if (dx_q == 0)
                cfl = (prod == 0) ? 0 : QMAX;
            else
                cfl = q_div(prod, dx_q);
            f.mom = q_clip(q_mul(m, u) + p);
            f.energy = q_mul(q_clip(e + p), u);
            f.pres = p;
            f.vel = u;
            f.temp = t;
            f.cfl = cfl;
        end
        if (first || cfl > peak_cfl)
            peak_cfl = cfl;
        f.maxc = peak_cfl;
        return f;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            $error("%s: expected %h, got %h", name, want, got);
        end
    endtask

    // result monitor
    always @(posedge clk) begin
        flux_t w;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_flux.size() == 0) begin
                errors++;
                $error("unexpected result: no request outstanding");
            end else begin
                w = pending_flux.pop_front();
                cells_checked++;
                check_field("mass_flux", w.mass[31:0], mass_flux);
                check_field("momentum_flux", w.mom[31:0], momentum_flux);
                check_field("energy_flux", w.energy[31:0], energy_flux);
                check_field("pressure", w.pres[31:0], pressure);
                check_field("velocity", w.vel[31:0], velocity);
                check_field("temperature", w.temp[31:0], temperature);
                check_field("min_speed", w.smin[31:0], min_speed);
                check_field("max_speed", w.smax[31:0], max_speed);
                check_field("mach_number", {1'b0, w.mach[30:0]}, {1'b0, mach_number});
                check_field("cfl_number", {1'b0, w.cfl[30:0]}, {1'b0, cfl_number});
                check_field("max_cfl", {1'b0, w.maxc[30:0]}, {1'b0, max_cfl});
                check_field("bad_state", {31'b0, w.bad}, {31'b0, bad_state});
            end
        end
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic reg_write(eigcf_pkg::reg_idx_t idx, logic [31:0] v);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 4'(idx) << 2;
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            eigcf_pkg::REG_GAMMA: gamma_q = v[17:0];
            eigcf_pkg::REG_GASC:  gasc_q = v[26:0];
            eigcf_pkg::REG_DT:    dt_q = v[30:0];
            eigcf_pkg::REG_DX:    dx_q = v[30:0];
        endcase
    endtask

    // one request; the known flag marks rows whose result is a bad state by inspection
    task automatic send_cell(logic [30:0] rho, logic [31:0] m, logic [31:0] e, bit first,
                             bit known);
        flux_t f;
        in_valid <= 1'b1;
        density <= rho;
        momentum <= m;
        total_energy <= e;
        first_cell <= first;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        f = cell_flux(rho, m, e, first);
        if (known) begin
            f = '{default: 0};
            f.mass = longint'($signed(m));
            f.bad = 1'b1;
            if (!first)
                f.maxc = peak_cfl;
        end
        pending_flux.push_back(f);
        cells_sent++;
        if ($urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_flux.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_cell();
        logic [30:0] rho;
        logic [31:0] m, e;
        int k, pick;
        pick = $urandom_range(99);
        if (pick < 60) begin
            rho = 31'($urandom_range(32'h0000_1000, 32'h0040_0000));
            m = $signed($urandom()) >>> $urandom_range(6, 20);
            e = $urandom_range(0, 32'h3fff_ffff) >> $urandom_range(0, 12);
        end else if (pick < 70) begin
            rho = 31'($urandom_range(1, 32'h7fff_ffff));
            m = '0;
            e = '0;
        end else if (pick < 78) begin
            k = $urandom_range(1, 40);
            rho = 31'd65536;
            m = 32'(k * 65536);
            e = 32'(k * k * 32768);
        end else begin
            rho = 31'($urandom() & 32'h7fff_ffff);
            if ($urandom_range(9) == 0)
                rho = '0;
            m = $urandom();
            e = $urandom();
        end
        send_cell(rho, m, e, $urandom_range(9) == 0, 1'b0);
    endtask

    cell_row_t directed[] = '{
        '{31'd0, 32'd0, 32'd0, 1'b1, 1'b1},
        '{31'd0, 32'h7fff_ffff, 32'h8000_0000, 1'b0, 1'b1},
        '{31'd0, 32'h8000_0000, 32'h7fff_ffff, 1'b0, 1'b1},
        '{31'd65536, 32'd0, 32'hffff_0000, 1'b1, 1'b1},
        '{31'd65536, 32'd0, 32'd0, 1'b0, 1'b0},
        '{31'd65536, 32'd65536, 32'd32768, 1'b0, 1'b0},
        '{31'd65536, 32'd131072, 32'd655360, 1'b1, 1'b0},
        '{31'd65536, 32'hfffe_0000, 32'd655360, 1'b0, 1'b0},
        '{31'd65536, 32'd65536, 32'd0, 1'b0, 1'b0},
        '{31'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, 1'b0},
        '{31'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0, 1'b0},
        '{31'd1, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, 1'b0},
        '{31'd1, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0},
        '{31'd1, 32'd0, 32'h7fff_ffff, 1'b0, 1'b0},
        '{31'd6554, 32'd13107, 32'd2000000, 1'b0, 1'b0},
        '{31'd655360, 32'h0100_0000, 32'h1000_0000, 1'b0, 1'b0},
        '{31'd655360, 32'h0100_0000, 32'h1000_0000, 1'b1, 1'b0},
        '{31'd65536, 32'd1, 32'd1, 1'b0, 1'b0},
        '{31'h4000_0000, 32'hc000_0000, 32'h4000_0000, 1'b0, 1'b0}
    };

    logic [31:0] settings[6][4] = '{
        '{32'd91750, 32'd18808832, 32'd655, 32'd65536},
        '{32'd196608, 32'd131072000, 32'h7fff_ffff, 32'd1},
        '{32'd65537, 32'd65536, 32'd1, 32'h7fff_ffff},
        '{32'd32768, 32'd0, 32'd65536, 32'd0},
        '{32'h3ffff, 32'h7ff_ffff, 32'd6554, 32'd3277},
        '{32'd0, 32'd65536, 32'd65536, 32'd65536}
    };

    int modes[4][2] = '{'{0, 0}, '{46, 0}, '{0, 46}, '{13, 13}};

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_cell(directed[i].rho, directed[i].m, directed[i].e,
                      directed[i].first, directed[i].known);
        drain();

        for (int s = 0; s < 7; s++) begin
            if (s < 6) begin
                reg_write(eigcf_pkg::REG_GAMMA, settings[s][0]);
                reg_write(eigcf_pkg::REG_GASC, settings[s][1]);
                reg_write(eigcf_pkg::REG_DT, settings[s][2]);
                reg_write(eigcf_pkg::REG_DX, settings[s][3]);
            end else begin
                reg_write(eigcf_pkg::REG_GAMMA, $urandom_range(65537, 196608));
                reg_write(eigcf_pkg::REG_GASC, $urandom_range(65536, 131072000));
                reg_write(eigcf_pkg::REG_DT, $urandom_range(1, 32'h7fff_ffff));
                reg_write(eigcf_pkg::REG_DX, $urandom_range(1, 32'h7fff_ffff));
            end
            settings_run++;
            for (int ph = 0; ph < 4; ph++) begin
                gap_pct = modes[ph][0];
                stall_pct = modes[ph][1];
                repeat (33) random_cell();
            end
            gap_pct = 0;
            stall_pct = 0;
            drain();
        end

        $display("Covered %0d requests (%0d checked) over %0d register settings,",
                 cells_sent, cells_checked, settings_run);
        $display("including bad states, zero sound speed, zero gas constant and zero width.");
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/eigcf_pkg.sv
sv/eigcf_div.sv
sv/eigcf_sqrt.sv
sv/euler_ideal_gas_cell_flux.sv
sim/euler_ideal_gas_cell_flux_test.sv
